// ===== rtl/core/ptde_pkg.sv =====
// Shared types, codes and saturation helpers for the trajectory derivative evaluator.
`default_nettype none

package ptde_pkg;

   localparam int ACC_W   = 64;
   localparam int PROD_W  = 66;
   localparam int SCALE_W = 70;
   localparam int FACT_W  = 5;
   localparam int TERM_W  = 5;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_EVAL  = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   localparam logic [1:0] CSR_TERM_COUNT   = 2'd0;
   localparam logic [1:0] CSR_START_OFFSET = 2'd1;
   localparam logic [1:0] CSR_DEV_LIMIT    = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         coef_index;
      logic signed [31:0] coef_x;
      logic signed [31:0] coef_y;
      logic [3:0]         deriv_order;
      logic signed [31:0] sample_time;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic               deviates;
      logic               not_loaded;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_SCL_X,
      ST_MUL_Y,
      ST_SCL_Y,
      ST_MUL_P,
      ST_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_L,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MS_NONE,
      MS_CX,
      MS_CY,
      MS_PD,
      MS_UX,
      MS_UY,
      MS_LIM
   } mul_sel_type;

   typedef struct packed {
      state_type           state;
      mul_sel_type         mul_sel;
      logic [FACT_W-1:0]   factor;
      logic                scale_done;
      logic                is_check;
   } ctrl_type;

   typedef struct packed {
      logic signed [31:0] coef_x;
      logic signed [31:0] coef_y;
      logic signed [31:0] power;
      logic signed [31:0] eval_t;
      logic [31:0]        ux;
      logic [31:0]        uy;
      logic [30:0]        lim;
   } mul_opnd_type;

   // Clamp a wide signed value to the signed 32 bit range.
   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = {{(PROD_W-31){1'b0}}, {31{1'b1}}};
      lo = {{(PROD_W-31){1'b1}}, {31{1'b0}}};
      if (v > hi) return 32'sh7FFF_FFFF;
      if (v < lo) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Clamp a scaled term to the signed 64 bit range.
   function automatic logic signed [ACC_W-1:0] sat64(input logic signed [SCALE_W-1:0] v);
      logic signed [SCALE_W-1:0] hi;
      logic signed [SCALE_W-1:0] lo;
      hi = {{(SCALE_W-63){1'b0}}, {63{1'b1}}};
      lo = {{(SCALE_W-63){1'b1}}, {63{1'b0}}};
      if (v > hi) return {1'b0, {63{1'b1}}};
      if (v < lo) return {1'b1, {63{1'b0}}};
      return v[ACC_W-1:0];
   endfunction

   // Saturating 64 bit add.
   function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
      return s[ACC_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ptde_coef_store.sv =====
// Coefficient pair store with per-entry valid bits and the loaded flag.
`default_nettype none

module ptde_coef_store #(
   parameter int MAX_TERMS = 8,
   parameter int IDX_W     = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [2:0]         wr_idx,
   input  wire logic signed [31:0] wr_x,
   input  wire logic signed [31:0] wr_y,
   input  wire logic [IDX_W-1:0]   rd_idx,
   output logic signed [31:0]      rd_x,
   output logic signed [31:0]      rd_y,
   output logic                    loaded
);
   import ptde_pkg::*;

   logic signed [31:0] coef_x_ff [MAX_TERMS];
   logic signed [31:0] coef_y_ff [MAX_TERMS];
   logic [MAX_TERMS-1:0] valid_ff;
   logic [MAX_TERMS-1:0] valid_in;
   logic                 loaded_ff;
   logic                 loaded_in;
   logic                 wr_ok;

   // Indexes past the array are dropped and leave the loaded flag alone.
   assign wr_ok = wr_en && (32'(wr_idx) < MAX_TERMS);

   always_comb begin
      valid_in  = valid_ff;
      loaded_in = loaded_ff;
      if (wr_ok) begin
         valid_in[IDX_W'(wr_idx)] = 1'b1;
         loaded_in                = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         loaded_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         loaded_ff <= loaded_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         coef_x_ff[IDX_W'(wr_idx)] <= wr_x;
         coef_y_ff[IDX_W'(wr_idx)] <= wr_y;
      end
   end

   assign rd_x   = valid_ff[rd_idx] ? coef_x_ff[rd_idx] : 32'sd0;
   assign rd_y   = valid_ff[rd_idx] ? coef_y_ff[rd_idx] : 32'sd0;
   assign loaded = loaded_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ptde_mul_unit.sv =====
// Shared 33 by 33 signed multiplier with its operand selection.
`default_nettype none

module ptde_mul_unit (
   input  wire ptde_pkg::mul_sel_type  sel,
   input  wire ptde_pkg::mul_opnd_type opnd,
   output logic signed [ptde_pkg::PROD_W-1:0] prod
);
   import ptde_pkg::*;

   logic signed [32:0] op_a;
   logic signed [32:0] op_b;

   always_comb begin
      unique case (sel)
         MS_CX: begin
            op_a = {opnd.coef_x[31], opnd.coef_x};
            op_b = {opnd.power[31], opnd.power};
         end
         MS_CY: begin
            op_a = {opnd.coef_y[31], opnd.coef_y};
            op_b = {opnd.power[31], opnd.power};
         end
         MS_PD: begin
            op_a = {opnd.power[31], opnd.power};
            op_b = {opnd.eval_t[31], opnd.eval_t};
         end
         MS_UX: begin
            op_a = {1'b0, opnd.ux};
            op_b = {1'b0, opnd.ux};
         end
         MS_UY: begin
            op_a = {1'b0, opnd.uy};
            op_b = {1'b0, opnd.uy};
         end
         MS_LIM: begin
            op_a = {2'b00, opnd.lim};
            op_b = {2'b00, opnd.lim};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod = op_a * op_b;

endmodule

`default_nettype wire

// ===== rtl/core/ptde_sequencer.sv =====
// Sequencer: walks terms and falling-factorial steps and the distance check.
`default_nettype none

module ptde_sequencer #(
   parameter int MAX_TERMS = 8,
   parameter int IDX_W     = 3,
   parameter int CNT_W     = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [1:0]     command,
   input  wire logic [3:0]     deriv_order,
   input  wire logic [3:0]     term_count,
   input  wire logic           loaded,
   output ptde_pkg::ctrl_type  ctrl,
   output logic [IDX_W-1:0]    coef_idx,
   output logic                busy
);
   import ptde_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] terms_ff, terms_in;
   logic             check_ff, check_in;
   logic [TERM_W-1:0] terms_cap;
   logic             order_ok;
   logic             k_done;
   logic             last_term;

   assign terms_cap = ({1'b0, term_count} > TERM_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS)
                                                               : {1'b0, term_count};
   assign order_ok  = {1'b0, deriv_order} < terms_cap;
   assign k_done    = (k_ff == n_ff);
   assign last_term = (CNT_W'(i_ff + 1'b1) == terms_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (command == CMD_EVAL) begin
                  state_in = (loaded && order_ok) ? ST_MUL_X : ST_DONE;
               end else if (command == CMD_CHECK) begin
                  if (!loaded)
                     state_in = ST_DONE;
                  else if (terms_cap == '0)
                     state_in = ST_DIFF;
                  else
                     state_in = ST_MUL_X;
               end
            end
         end
         ST_MUL_X: state_in = ST_SCL_X;
         ST_SCL_X: if (k_done) state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_SCL_Y;
         ST_SCL_Y: if (k_done) state_in = ST_MUL_P;
         ST_MUL_P: begin
            if (!last_term)
               state_in = ST_MUL_X;
            else
               state_in = check_ff ? ST_DIFF : ST_DONE;
         end
         ST_DIFF:  state_in = ST_SQ_X;
         ST_SQ_X:  state_in = ST_SQ_Y;
         ST_SQ_Y:  state_in = ST_SQ_L;
         ST_SQ_L:  state_in = ST_CMP;
         ST_CMP:   state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      i_in     = i_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      terms_in = terms_ff;
      check_in = check_ff;
      if (state_ff == ST_IDLE && accept) begin
         check_in = (command == CMD_CHECK);
         n_in     = (command == CMD_CHECK) ? '0 : CNT_W'(deriv_order);
         i_in     = (command == CMD_CHECK) ? '0 : CNT_W'(deriv_order);
         k_in     = '0;
         terms_in = CNT_W'(terms_cap);
      end else if (state_ff == ST_SCL_X || state_ff == ST_SCL_Y) begin
         k_in = k_done ? '0 : CNT_W'(k_ff + 1'b1);
      end else if (state_ff == ST_MUL_P) begin
         i_in = CNT_W'(i_ff + 1'b1);
      end
   end

   always_comb begin
      ctrl.state      = state_ff;
      ctrl.factor     = FACT_W'(CNT_W'(i_ff - k_ff));
      ctrl.scale_done = k_done;
      ctrl.is_check   = check_ff;
      unique case (state_ff)
         ST_MUL_X: ctrl.mul_sel = MS_CX;
         ST_MUL_Y: ctrl.mul_sel = MS_CY;
         ST_MUL_P: ctrl.mul_sel = MS_PD;
         ST_SQ_X:  ctrl.mul_sel = MS_UX;
         ST_SQ_Y:  ctrl.mul_sel = MS_UY;
         ST_SQ_L:  ctrl.mul_sel = MS_LIM;
         default:  ctrl.mul_sel = MS_NONE;
      endcase
   end

   assign coef_idx = i_ff[IDX_W-1:0];
   assign busy     = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         k_ff     <= '0;
         n_ff     <= '0;
         terms_ff <= '0;
         check_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         terms_ff <= terms_in;
         check_ff <= check_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/polynomial_trajectory_derivative_eval.sv =====
// Top level: planar polynomial trajectory derivative evaluation and deviation check.
//
//   Channel   Ports                          Beat moves on
//   request   start, busy, req_data          start high while busy low
//   response  rsp_strobe, rsp_data           rsp_strobe high, one cycle
//   config    csr_we, csr_index, csr_wdata   csr_we high
//
// A load beat is absorbed in the cycle it is accepted and leaves busy low.
// An evaluate of order n over T terms walks the terms when T > n and it is loaded,
// else goes straight to the done state. A check is an order zero pass followed by the
// distance step, which also runs when T is zero; before any load a check goes straight
// to the done state. The rate is set by the single shared multiplier, which takes two
// coefficient products and one power update per term, and by the n falling-factorial
// scaling steps per axis and term.
// Reset is synchronous and active high and clears all coefficients to unloaded.
// The receiver cannot stall: each result beat shows for exactly one cycle.
`default_nettype none

module polynomial_trajectory_derivative_eval #(
   parameter int MAX_TERMS = 8,
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ptde_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output ptde_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);
   import ptde_pkg::*;

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

   // Configuration registers.
   logic [3:0]         term_count_ff;
   logic signed [31:0] start_offset_ff;
   logic [30:0]        dev_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff   <= '0;
         start_offset_ff <= '0;
         dev_limit_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TERM_COUNT:   term_count_ff   <= csr_wdata[3:0];
            CSR_START_OFFSET: start_offset_ff <= csr_wdata;
            CSR_DEV_LIMIT:    dev_limit_ff    <= csr_wdata[30:0];
            default:          ;
         endcase
      end
   end

   logic accept;
   assign accept = start && !busy;

   // Coefficient store.
   logic               store_wr;
   logic [IDX_W-1:0]   coef_idx;
   logic signed [31:0] coef_x;
   logic signed [31:0] coef_y;
   logic               loaded;

   assign store_wr = accept && (req_data.command == CMD_LOAD);

   ptde_coef_store #(
      .MAX_TERMS(MAX_TERMS),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (store_wr),
      .wr_idx (req_data.coef_index),
      .wr_x   (req_data.coef_x),
      .wr_y   (req_data.coef_y),
      .rd_idx (coef_idx),
      .rd_x   (coef_x),
      .rd_y   (coef_y),
      .loaded (loaded)
   );

   // Sequencer.
   ctrl_type ctrl;

   ptde_sequencer #(
      .MAX_TERMS(MAX_TERMS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_data.command),
      .deriv_order (req_data.deriv_order),
      .term_count  (term_count_ff),
      .loaded      (loaded),
      .ctrl        (ctrl),
      .coef_idx    (coef_idx),
      .busy        (busy)
   );

   // Datapath registers.
   logic signed [31:0]      eval_t_ff, eval_t_in;
   logic signed [31:0]      power_ff, power_in;
   logic signed [ACC_W-1:0] acc_x_ff, acc_x_in;
   logic signed [ACC_W-1:0] acc_y_ff, acc_y_in;
   logic signed [ACC_W-1:0] term_ff, term_in;
   logic signed [31:0]      pt_x_ff, pt_x_in;
   logic signed [31:0]      pt_y_ff, pt_y_in;
   logic [31:0]             ux_ff, ux_in;
   logic [31:0]             uy_ff, uy_in;
   logic [63:0]             sx_ff, sx_in;
   logic [63:0]             sy_ff, sy_in;
   logic [61:0]             lim2_ff, lim2_in;
   logic                    dev_ff, dev_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   // Shared multiplier.
   mul_opnd_type             opnd;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_q;

   assign opnd.coef_x = coef_x;
   assign opnd.coef_y = coef_y;
   assign opnd.power  = power_ff;
   assign opnd.eval_t = eval_t_ff;
   assign opnd.ux     = ux_ff;
   assign opnd.uy     = uy_ff;
   assign opnd.lim    = dev_limit_ff;

   ptde_mul_unit u_mul (
      .sel  (ctrl.mul_sel),
      .opnd (opnd),
      .prod (prod)
   );

   // Floor shift back to the fixed-point scale; arithmetic shift rounds down.
   assign prod_q = prod >>> FRAC_BITS;

   // Falling-factorial scaling: one integer factor per cycle, saturating each time.
   // The factors are all at least one, so saturating early gives the same result.
   logic signed [5:0]         fact_s;
   logic signed [SCALE_W-1:0] scaled;
   assign fact_s = $signed({1'b0, ctrl.factor});
   assign scaled = term_ff * fact_s;

   // Time offset sum, saturated to 32 bits.
   logic signed [32:0] time_sum;
   assign time_sum = {req_data.sample_time[31], req_data.sample_time}
                   + {start_offset_ff[31], start_offset_ff};

   // Position deltas for the check.
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic signed [32:0] dx_neg;
   logic signed [32:0] dy_neg;
   logic [64:0]        sq_sum;

   assign pos_x  = sat32({{(PROD_W-ACC_W){acc_x_ff[ACC_W-1]}}, acc_x_ff});
   assign pos_y  = sat32({{(PROD_W-ACC_W){acc_y_ff[ACC_W-1]}}, acc_y_ff});
   assign dx     = {pos_x[31], pos_x} - {pt_x_ff[31], pt_x_ff};
   assign dy     = {pos_y[31], pos_y} - {pt_y_ff[31], pt_y_ff};
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   // The sum is kept a bit wider so that it never wraps.
   assign sq_sum = {1'b0, sx_ff} + {1'b0, sy_ff};

   always_comb begin
      eval_t_in     = eval_t_ff;
      power_in      = power_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      term_in       = term_ff;
      pt_x_in       = pt_x_ff;
      pt_y_in       = pt_y_ff;
      ux_in         = ux_ff;
      uy_in         = uy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      lim2_in       = lim2_ff;
      dev_in        = dev_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      case (ctrl.state)
         ST_IDLE: begin
            if (accept) begin
               eval_t_in = sat32({{(PROD_W-33){time_sum[32]}}, time_sum});
               power_in  = ONE_Q;
               acc_x_in  = '0;
               acc_y_in  = '0;
               pt_x_in   = req_data.point_x;
               pt_y_in   = req_data.point_y;
               dev_in    = 1'b0;
            end
         end
         ST_MUL_X, ST_MUL_Y: term_in = prod_q[ACC_W-1:0];
         ST_SCL_X: begin
            if (ctrl.scale_done)
               acc_x_in = sat_add64(acc_x_ff, term_ff);
            else
               term_in = sat64(scaled);
         end
         ST_SCL_Y: begin
            if (ctrl.scale_done)
               acc_y_in = sat_add64(acc_y_ff, term_ff);
            else
               term_in = sat64(scaled);
         end
         ST_MUL_P: power_in = sat32(prod_q);
         ST_DIFF: begin
            ux_in = dx[32] ? dx_neg[31:0] : dx[31:0];
            uy_in = dy[32] ? dy_neg[31:0] : dy[31:0];
         end
         ST_SQ_X: sx_in   = prod[63:0];
         ST_SQ_Y: sy_in   = prod[63:0];
         ST_SQ_L: lim2_in = prod[61:0];
         ST_CMP:  dev_in  = sq_sum > {3'b000, lim2_ff};
         ST_DONE: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.value_x    = pos_x;
            rsp_in.value_y    = pos_y;
            rsp_in.deviates   = ctrl.is_check && (dev_ff || !loaded);
            rsp_in.not_loaded = !loaded;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_t_ff <= eval_t_in;
      power_ff  <= power_in;
      acc_x_ff  <= acc_x_in;
      acc_y_ff  <= acc_y_in;
      term_ff   <= term_in;
      pt_x_ff   <= pt_x_in;
      pt_y_ff   <= pt_y_in;
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      lim2_ff   <= lim2_in;
      dev_ff    <= dev_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every result beat passes through a done cycle, so two never come back to back.
   a_no_double_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result beats in consecutive cycles");

   // A load is absorbed at once and does not make the block busy.
   a_load_not_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_LOAD) |=> !busy)
      else $error("load beat made the block busy");

   // Evaluate and check always make the sequencer busy.
   a_work_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.command == CMD_EVAL || req_data.command == CMD_CHECK))
      |=> busy)
      else $error("evaluate or check did not start the sequencer");

   // Without coefficients the values must read as zero.
   a_unloaded_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.not_loaded) |-> (rsp_data.value_x == 32'sd0 &&
                                               rsp_data.value_y == 32'sd0))
      else $error("nonzero value before any load");

endmodule

`default_nettype wire

// ===== test/polynomial_trajectory_derivative_eval_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the planar polynomial trajectory derivative evaluator.

module polynomial_trajectory_derivative_eval_test;
   import ptde_pkg::*;

   // Depth of each coefficient store and the Q16.16 fraction width of the block.
   localparam int COEF_SLOTS = 8;
   localparam int FRAC = 16;

   // The longest busy window is an evaluate of order 3 over eight terms, and a check over
   // eight terms is shorter. Waiting a little longer than that makes sure a trailing load
   // has also been absorbed before registers change.
   localparam int SETTLE_CYCLES = 80;

   // The watchdog limit lies above the length of a correct run, even one in which every
   // beat meets the longest busy window and the longest sender gap.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   localparam int RANDOM_PHASES   = 6;
   localparam int BEATS_PER_PHASE = 88;
   localparam int MAX_REPORTS     = 40;

   // Codes the package leaves unnamed because the block ignores them.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // Where a check beat puts its measured point relative to the predicted position.
   typedef enum logic [2:0] {
      PT_ON_PATH,
      PT_ON_EDGE,
      PT_JUST_OUT,
      PT_NEAR,
      PT_ANYWHERE
   } point_kind;

   // Mirrors the coefficient stores and registers of the block, predicts the
   // result of every accepted beat and compares the result beats in order.
   class TrajectoryScoreboard;
      logic signed [31:0] x_coef [COEF_SLOTS];
      logic signed [31:0] y_coef [COEF_SLOTS];
      bit                 loaded;
      logic [3:0]         terms_cfg;
      logic signed [31:0] offset_cfg;
      logic [30:0]        limit_cfg;
      rsp_type            expected_rsp [$];
      int                 mismatches;
      int                 results_checked;
      int                 deviations_expected;
      int                 loads;
      int                 evaluates;
      int                 checks;
      int                 ignored;

      function new();
         foreach (x_coef[i]) begin
            x_coef[i] = '0;
            y_coef[i] = '0;
         end
         loaded     = 1'b0;
         terms_cfg  = '0;
         offset_cfg = '0;
         limit_cfg  = '0;
      endfunction

      function logic signed [31:0] sat_q16(longint v);
         if (v > 64'sh0000_0000_7FFF_FFFF) return Q_MAX;
         if (v < 64'shFFFF_FFFF_8000_0000) return Q_MIN;
         return v[31:0];
      endfunction

      // Derivative of the given order of both axes at t plus the start offset.
      // Each term is at most 2^46 times 7! and eight of them stay far inside
      // 64 bits, so only the 32 bit clamps can ever bind.
      function void trajectory(input logic [3:0] order, input logic signed [31:0] t,
                               output logic signed [31:0] vx,
                               output logic signed [31:0] vy);
         int     used;
         longint tt;
         longint off;
         longint d;
         longint power;
         longint factor;
         longint cx;
         longint cy;
         longint acc_x;
         longint acc_y;
         used  = (terms_cfg > COEF_SLOTS) ? COEF_SLOTS : terms_cfg;
         tt    = t;
         off   = offset_cfg;
         d     = sat_q16(tt + off);
         power = Q_ONE;
         acc_x = 0;
         acc_y = 0;
         for (int i = order; i < used; i++) begin
            factor = 1;
            for (int k = 0; k < order; k++) factor = factor * (i - k);
            cx    = x_coef[i];
            cy    = y_coef[i];
            acc_x = acc_x + ((cx * power) >>> FRAC) * factor;
            acc_y = acc_y + ((cy * power) >>> FRAC) * factor;
            power = sat_q16((power * d) >>> FRAC);
         end
         vx = sat_q16(acc_x);
         vy = sat_q16(acc_y);
      endfunction

      function void write_config(logic [1:0] index, logic [31:0] data);
         case (index)
            CSR_TERM_COUNT:   terms_cfg  = data[3:0];
            CSR_START_OFFSET: offset_cfg = data;
            CSR_DEV_LIMIT:    limit_cfg  = data[30:0];
            default: ;
         endcase
      endfunction

      function void note_input(req_type beat);
         rsp_type            rsp;
         logic signed [31:0] vx;
         logic signed [31:0] vy;
         longint             dx;
         longint             dy;
         logic [63:0]        ux;
         logic [63:0]        uy;
         logic [63:0]        lim_sq;
         logic [64:0]        dist_sq;
         rsp = '0;
         case (beat.command)
            CMD_LOAD: begin
               // Every 3 bit index fits the store, so a load always lands.
               x_coef[beat.coef_index] = beat.coef_x;
               y_coef[beat.coef_index] = beat.coef_y;
               loaded = 1'b1;
               loads++;
               return;
            end
            CMD_EVAL: begin
               evaluates++;
               if (loaded) begin
                  trajectory(beat.deriv_order, beat.sample_time, vx, vy);
                  rsp.value_x = vx;
                  rsp.value_y = vy;
               end
            end
            CMD_CHECK: begin
               checks++;
               if (!loaded) begin
                  rsp.deviates = 1'b1;
               end else begin
                  trajectory(4'd0, beat.sample_time, vx, vy);
                  rsp.value_x = vx;
                  rsp.value_y = vy;
                  dx = longint'(vx) - longint'(beat.point_x);
                  dy = longint'(vy) - longint'(beat.point_y);
                  ux = (dx < 0) ? -dx : dx;
                  uy = (dy < 0) ? -dy : dy;
                  // The sum is kept one bit wider so it can never wrap.
                  dist_sq = ux * ux + uy * uy;
                  lim_sq  = limit_cfg * limit_cfg;
                  rsp.deviates = (dist_sq > lim_sq);
               end
            end
            default: begin
               ignored++;
               return;
            end
         endcase
         rsp.not_loaded = !loaded;
         if (rsp.deviates) deviations_expected++;
         expected_rsp.push_back(rsp);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing outstanding", got));
            return;
         end
         want = expected_rsp.pop_front();
         results_checked++;
         if (got.value_x !== want.value_x)
            report_mismatch($sformatf("value_x %h, predicted %h", got.value_x, want.value_x));
         if (got.value_y !== want.value_y)
            report_mismatch($sformatf("value_y %h, predicted %h", got.value_y, want.value_y));
         if (got.deviates !== want.deviates)
            report_mismatch($sformatf("deviates %b, predicted %b", got.deviates, want.deviates));
         if (got.not_loaded !== want.not_loaded)
            report_mismatch($sformatf("not_loaded %b, predicted %b", got.not_loaded,
                                      want.not_loaded));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   TrajectoryScoreboard sb = new();
   int unsigned         cycle_count = 0;
   int                  settings_written = 0;

   polynomial_trajectory_derivative_eval u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver cannot hold results off, so every strobe is a beat to compare.
   // All block outputs change on nonblocking updates, so the values read here are
   // the ones that stood during the cycle that this edge ends.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_data);
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("polynomial_trajectory_derivative_eval_test: FAIL");
         $finish;
      end
   end

   // Presents one beat and holds it until the block takes it. The beat is noted
   // in the scoreboard at the accepting edge, so its state is current as soon as
   // this task returns.
   task automatic drive_beat(req_type beat);
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_input(beat);
   endtask

   // Lowers start only when time really passes, so that a following beat never
   // lowers and raises it within one step.
   task automatic idle_sender(int unsigned cycles);
      if (cycles != 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_results();
      if (sb.expected_rsp.size() != 0) begin
         start <= 1'b0;
         while (sb.expected_rsp.size() != 0) @(posedge clock);
      end
   endtask

   // Brings the block to idle before registers change: every result is in, and a
   // trailing load or ignored beat has had time to finish.
   task automatic quiesce();
      wait_results();
      idle_sender(SETTLE_CYCLES);
   endtask

   // Leaves the write enable high; the caller lowers it after its last write.
   task automatic write_csr(logic [1:0] index, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_config(index, data);
   endtask

   // Bits above each register's width carry random values, which the block drops.
   task automatic program_config(logic [3:0] terms, logic signed [31:0] offset,
                                 logic [30:0] limit);
      write_csr(CSR_TERM_COUNT, {28'($urandom), terms});
      write_csr(CSR_START_OFFSET, offset);
      write_csr(CSR_DEV_LIMIT, {1'($urandom), limit});
      csr_we <= 1'b0;
      settings_written++;
   endtask

   // Mostly small values so that polynomials stay in range, with the extremes
   // and the full 32 bit range mixed in.
   function automatic logic signed [31:0] rand_q16(int unsigned span);
      case ($urandom_range(0, 9))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2, 3:    return $urandom();
         default: return int'($urandom_range(0, 2 * span)) - int'(span);
      endcase
   endfunction

   // Fields that a command does not use still toggle every bit.
   function automatic req_type random_fields();
      req_type b;
      b.command     = CMD_UNUSED;
      b.coef_index  = 3'($urandom_range(0, 7));
      b.coef_x      = $urandom();
      b.coef_y      = $urandom();
      b.deriv_order = 4'($urandom_range(0, 15));
      b.sample_time = $urandom();
      b.point_x     = $urandom();
      b.point_y     = $urandom();
      return b;
   endfunction

   function automatic req_type load_beat(logic [2:0] index, logic signed [31:0] cx,
                                         logic signed [31:0] cy);
      req_type b;
      b            = random_fields();
      b.command    = CMD_LOAD;
      b.coef_index = index;
      b.coef_x     = cx;
      b.coef_y     = cy;
      return b;
   endfunction

   function automatic req_type eval_beat(logic [3:0] order, logic signed [31:0] t);
      req_type b;
      b             = random_fields();
      b.command     = CMD_EVAL;
      b.deriv_order = order;
      b.sample_time = t;
      return b;
   endfunction

   // Places the measured point relative to the position that the scoreboard
   // predicts, so that the on-path, on-limit and just-outside cases all occur.
   function automatic req_type check_beat(logic signed [31:0] t, point_kind kind);
      req_type            b;
      logic signed [31:0] px;
      logic signed [31:0] py;
      longint             lim;
      longint             dx;
      longint             dy;
      b             = random_fields();
      b.command     = CMD_CHECK;
      b.sample_time = t;
      sb.trajectory(4'd0, t, px, py);
      lim = sb.limit_cfg;
      dx  = 0;
      dy  = 0;
      case (kind)
         PT_ON_EDGE:  dx = lim;
         PT_JUST_OUT: dx = lim + 1;
         PT_NEAR: begin
            dx = $urandom_range(0, 32'(lim + lim / 4 + 2));
            dy = $urandom_range(0, 32'(lim + lim / 4 + 2));
         end
         default: ;
      endcase
      if ($urandom_range(0, 1)) {dx, dy} = {dy, dx};
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      b.point_x = sb.sat_q16(longint'(px) + dx);
      b.point_y = sb.sat_q16(longint'(py) + dy);
      if (kind == PT_ANYWHERE) begin
         b.point_x = $urandom();
         b.point_y = $urandom();
      end
      return b;
   endfunction

   // Loads keep reshaping the trajectory between evaluates and checks, and a
   // small share of beats carries the ignored command.
   function automatic req_type random_beat();
      int unsigned pick;
      logic [3:0]  order;
      pick = $urandom_range(0, 99);
      if (pick < 28)
         return load_beat(3'($urandom_range(0, 7)), rand_q16(32'h0004_0000),
                          rand_q16(32'h0004_0000));
      if (pick < 60) begin
         order = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
         return eval_beat(order, rand_q16(32'h0002_0000));
      end
      if (pick < 95)
         return check_beat(rand_q16(32'h0002_0000), point_kind'($urandom_range(0, 4)));
      return random_fields();
   endfunction

   // Mostly back to back or short gaps, now and then one that outlasts the
   // block's longest busy window.
   function automatic int unsigned random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic send(req_type beat);
      drive_beat(beat);
      idle_sender($urandom_range(0, 2));
   endtask

   initial begin : stimulus
      req_type beat;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_TERM_COUNT;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      quiesce();

      // Directed part. A write to the unused register index must change nothing.
      write_csr(CSR_UNUSED, $urandom());
      program_config(4'd8, 32'sd0, 31'(Q_ONE));

      // Nothing loaded yet: an evaluate reads zeros and a check always deviates.
      send(eval_beat(4'd0, Q_ONE));
      send(check_beat(Q_ONE, PT_ON_PATH));
      send(random_fields());

      // Only slot 2 is written; the other slots must read as zero.
      send(load_beat(3'd2, 32'sh0003_0000, -Q_ONE));
      send(eval_beat(4'd0, 32'sh0002_0000));
      send(eval_beat(4'd1, 32'sh0002_0000));
      send(eval_beat(4'd2, 32'sh0002_0000));
      send(eval_beat(4'd3, 32'sh0002_0000));

      // Extreme coefficients in the top slot and extreme times drive saturation.
      send(load_beat(3'd7, Q_MAX, Q_MIN));
      send(eval_beat(4'd0, Q_MAX));
      send(eval_beat(4'd0, Q_MIN));
      send(eval_beat(4'd7, Q_MAX));
      // Orders at or above the term count give zero.
      send(eval_beat(4'd8, Q_ONE));
      send(eval_beat(4'd15, Q_ONE));

      send(load_beat(3'd0, Q_MIN, Q_MAX));
      send(check_beat(32'sd0, PT_ON_PATH));
      send(check_beat(Q_ONE, PT_ON_EDGE));
      send(check_beat(-Q_ONE, PT_JUST_OUT));
      send(check_beat(Q_MAX, PT_ANYWHERE));
      beat         = check_beat(Q_MIN, PT_ON_PATH);
      beat.point_x = Q_MAX;
      beat.point_y = Q_MIN;
      send(beat);
      send(eval_beat(4'd1, Q_MAX));

      // Random part. The first phases pin the register extremes: a term count
      // beyond the store, no terms at all, the offset limits and both limit ends.
      // Phase 1 runs without the random sender gaps.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiesce();
         case (p)
            0: program_config(4'd8, 32'sd0, 31'(Q_ONE));
            1: program_config(4'd15, Q_MAX, 31'h7FFF_FFFF);
            2: program_config(4'd0, Q_MIN, 31'd0);
            3: program_config(4'd1, rand_q16(32'h0002_0000),
                              31'($urandom_range(0, 32'h0004_0000)));
            default: program_config(4'($urandom_range(0, 15)), rand_q16(32'h0002_0000),
                                    ($urandom_range(0, 3) == 0)
                                       ? 31'($urandom())
                                       : 31'($urandom_range(0, 32'h0004_0000)));
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            drive_beat(random_beat());
            if (p != 1) idle_sender(random_gap());
            // Now and then hold the sender until every result has come back.
            if ($urandom_range(0, 99) < 3) wait_results();
         end
      end

      quiesce();
      $display("Covered %0d loads, %0d evaluates, %0d checks and %0d ignored beats",
               sb.loads, sb.evaluates, sb.checks, sb.ignored);
      $display("over %0d register settings; %0d results compared, %0d deviations expected.",
               settings_written, sb.results_checked, sb.deviations_expected);
      if (sb.mismatches == 0) begin
         $display("polynomial_trajectory_derivative_eval_test: PASS");
      end else begin
         $display("polynomial_trajectory_derivative_eval_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ptde_pkg.sv
rtl/core/ptde_coef_store.sv
rtl/core/ptde_mul_unit.sv
rtl/core/ptde_sequencer.sv
rtl/core/polynomial_trajectory_derivative_eval.sv
test/polynomial_trajectory_derivative_eval_test.sv
